// ===== sv/hlbe_pkg.sv =====
// ----------------------------------------------------------------------------
// hlbe_pkg
// Shared types, constants and helpers of the half lattice ball enumerator.
// ----------------------------------------------------------------------------
package hlbe_pkg;

    localparam int INDEX_MAX = 255;
    localparam int BOUND_W   = 8;
    localparam int IDX_W     = 10;
    localparam int CMP_W     = 21;
    localparam int BASIS_W   = 63;
    localparam int VEC_W     = 32;
    localparam int NORM_W    = 64;
    localparam int CUT_W     = 48;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        PH_ORIGIN,
        PH_AXIS,
        PH_PLANE,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_MAC,
        OP_SQ,
        OP_ROOT,
        OP_LOAD
    } t_dp_op;

    typedef struct packed {
        logic restart;
        logic step;
        logic advance;
        logic set_done;
    } t_walk_cmd;

    typedef struct packed {
        logic hit;
        logic fail;
        logic finished;
        logic origin;
    } t_walk_sts;

    typedef struct packed {
        t_dp_op           op;
        logic [CNT_W-1:0] cnt;
        logic             idle;
        logic             done;
    } t_dp_cmd;

    function automatic logic [BOUND_W-1:0] clamp_bound(input logic [BOUND_W-1:0] b);
        return (32'(b) > INDEX_MAX) ? BOUND_W'(INDEX_MAX) : b;
    endfunction

    function automatic logic signed [CMP_W-1:0] component(
        input logic [BASIS_W-1:0] packed_vec,
        input logic [1:0]         c
    );
        logic [BASIS_W-1:0] sh;
        sh = packed_vec >> (CMP_W * 32'(c));
        return $signed(sh[CMP_W-1:0]);
    endfunction

endpackage

// ===== sv/hlbe_walk.sv =====
// ----------------------------------------------------------------------------
// hlbe_walk
// Walk position: phase, indices and done flag, with one settle step per cycle while a step is commanded.
// ----------------------------------------------------------------------------
module hlbe_walk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hlbe_pkg::t_walk_cmd              i_cmd,
    input  logic [hlbe_pkg::BOUND_W-1:0]     i_b1,
    input  logic [hlbe_pkg::BOUND_W-1:0]     i_b2,
    input  logic [hlbe_pkg::BOUND_W-1:0]     i_b3,
    input  logic                             i_inc_origin,
    output hlbe_pkg::t_walk_sts              o_sts,
    output logic signed [hlbe_pkg::IDX_W-1:0] o_i1,
    output logic signed [hlbe_pkg::IDX_W-1:0] o_i2,
    output logic signed [hlbe_pkg::IDX_W-1:0] o_i3
);
    import hlbe_pkg::*;

    localparam logic signed [IDX_W-1:0] ONE  = IDX_W'(1);
    localparam logic signed [IDX_W-1:0] ZERO = '0;

    t_phase                  r_ph, n_ph;
    logic signed [IDX_W-1:0] r_i1, r_i2, r_i3;
    logic signed [IDX_W-1:0] t1, t2, t3;
    logic signed [IDX_W-1:0] bb1, bb2, bb3;
    logic                    r_fin;
    logic                    hit, fail;

    assign bb1 = $signed({2'b00, i_b1});
    assign bb2 = $signed({2'b00, i_b2});
    assign bb3 = $signed({2'b00, i_b3});

    always_comb begin
        t1   = r_i1;
        t2   = r_i2;
        t3   = r_i3;
        n_ph = r_ph;
        hit  = 1'b0;
        fail = 1'b0;
        unique case (r_ph)
            PH_ORIGIN: begin
                if (i_inc_origin) begin
                    hit = 1'b1;
                end else begin
                    n_ph = PH_AXIS;
                    t3   = ONE;
                end
            end
            PH_AXIS: begin
                if (t3 < ONE) t3 = ONE;
                if (t3 <= bb3) begin
                    hit = 1'b1;
                end else begin
                    n_ph = PH_PLANE;
                    t2   = ONE;
                    t3   = ZERO - bb3;
                end
            end
            PH_PLANE: begin
                if (t2 < ONE) begin
                    t2 = ONE;
                    t3 = ZERO - bb3;
                end
                if (t2 > bb2) begin
                    n_ph = PH_BODY;
                    t1   = ONE;
                    t2   = ZERO - bb2;
                    t3   = ZERO - bb3;
                end else if (t3 < ZERO - bb3) begin
                    t3 = ZERO - bb3;
                end else if (t3 > bb3) begin
                    t2 = t2 + ONE;
                    t3 = ZERO - bb3;
                end else begin
                    hit = 1'b1;
                end
            end
            PH_BODY: begin
                if (t1 < ONE) begin
                    t1 = ONE;
                    t2 = ZERO - bb2;
                    t3 = ZERO - bb3;
                end
                if (t1 > bb1) begin
                    fail = 1'b1;
                end else if (t2 < ZERO - bb2) begin
                    t2 = ZERO - bb2;
                    t3 = ZERO - bb3;
                end else if (t2 > bb2) begin
                    t1 = t1 + ONE;
                    t2 = ZERO - bb2;
                    t3 = ZERO - bb3;
                end else if (t3 < ZERO - bb3) begin
                    t3 = ZERO - bb3;
                end else if (t3 > bb3) begin
                    t2 = t2 + ONE;
                    t3 = ZERO - bb3;
                end else begin
                    hit = 1'b1;
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_ORIGIN;
            r_i1  <= '0;
            r_i2  <= '0;
            r_i3  <= '0;
            r_fin <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_ph  <= PH_ORIGIN;
                r_i1  <= '0;
                r_i2  <= '0;
                r_i3  <= '0;
                r_fin <= 1'b0;
            end else if (i_cmd.step) begin
                r_ph <= n_ph;
                r_i1 <= t1;
                r_i2 <= t2;
                r_i3 <= t3;
            end else if (i_cmd.advance) begin
                if (r_ph == PH_ORIGIN) begin
                    r_ph <= PH_AXIS;
                    r_i3 <= ONE;
                end else begin
                    r_i3 <= r_i3 + ONE;
                end
            end
            if (i_cmd.set_done) r_fin <= 1'b1;
        end
    end

    assign o_sts.hit      = hit;
    assign o_sts.fail     = fail;
    assign o_sts.finished = r_fin;
    assign o_sts.origin   = (r_ph == PH_ORIGIN);
    assign o_i1 = r_i1;
    assign o_i2 = r_i2;
    assign o_i3 = r_i3;

endmodule

// ===== sv/hlbe_dp.sv =====
// ----------------------------------------------------------------------------
// hlbe_dp
// Arithmetic: vector multiply-accumulate, squared norm, two-bit-per-cycle
// integer square root, and the result register.
// ----------------------------------------------------------------------------
module hlbe_dp (
    input  logic                              i_clk,
    input  hlbe_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_origin,
    input  logic signed [hlbe_pkg::IDX_W-1:0] i_i1,
    input  logic signed [hlbe_pkg::IDX_W-1:0] i_i2,
    input  logic signed [hlbe_pkg::IDX_W-1:0] i_i3,
    input  logic [hlbe_pkg::BASIS_W-1:0]      i_basis1,
    input  logic [hlbe_pkg::BASIS_W-1:0]      i_basis2,
    input  logic [hlbe_pkg::BASIS_W-1:0]      i_basis3,
    input  logic [hlbe_pkg::CUT_W-1:0]        i_cutoff,
    output logic                              o_point_valid,
    output logic [hlbe_pkg::VEC_W-1:0]        o_vec_x,
    output logic [hlbe_pkg::VEC_W-1:0]        o_vec_y,
    output logic [hlbe_pkg::VEC_W-1:0]        o_vec_z,
    output logic [hlbe_pkg::VEC_W-1:0]        o_vec_length,
    output logic                              o_walk_done
);
    import hlbe_pkg::*;

    logic signed [VEC_W-1:0]       r_acc [3];
    logic [NORM_W-1:0]             r_sq, r_norm, r_x, r_res;
    logic                          r_valid;
    logic [1:0]                    sel_c, sel_t, sel_q;
    logic signed [IDX_W-1:0]       m_idx;
    logic [BASIS_W-1:0]            m_basis;
    logic signed [IDX_W+CMP_W-1:0] prod;
    logic signed [NORM_W-1:0]      sq;
    logic [NORM_W-1:0]             x_a, r_a, b_a, x_b, r_b, b_b;
    logic [CNT_W:0]                sidx;

    assign sel_c = i_cmd.cnt[3:2];
    assign sel_t = i_cmd.cnt[1:0];
    assign sel_q = (sel_t == 2'd3) ? 2'd2 : sel_t;

    always_comb begin
        unique case (sel_t)
            2'd0:    begin m_idx = i_i1; m_basis = i_basis1; end
            2'd1:    begin m_idx = i_i2; m_basis = i_basis2; end
            default: begin m_idx = i_i3; m_basis = i_basis3; end
        endcase
    end

    assign prod = m_idx * component(m_basis, sel_c);
    assign sq   = r_acc[sel_q] * r_acc[sel_q];

    always_comb begin
        sidx = {i_cmd.cnt - CNT_W'(1), 1'b0};
        b_a  = 64'h4000_0000_0000_0000 >> {sidx, 1'b0};
        b_b  = b_a >> 2;
        x_a  = r_x;
        r_a  = r_res >> 1;
        if (r_x >= r_res + b_a) begin
            x_a = r_x - (r_res + b_a);
            r_a = (r_res >> 1) + b_a;
        end
        x_b = x_a;
        r_b = r_a >> 1;
        if (x_a >= r_a + b_b) begin
            x_b = x_a - (r_a + b_b);
            r_b = (r_a >> 1) + b_b;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CLEAR: begin
                r_acc[0] <= '0;
                r_acc[1] <= '0;
                r_acc[2] <= '0;
                r_norm   <= '0;
            end
            OP_MAC: begin
                r_acc[sel_c] <= r_acc[sel_c] + VEC_W'(prod);
            end
            OP_SQ: begin
                if (i_cmd.cnt != '0) r_norm <= r_norm + r_sq;
                r_sq <= sq;
            end
            OP_ROOT: begin
                if (i_cmd.cnt == '0) begin
                    r_x     <= r_norm;
                    r_res   <= '0;
                    r_valid <= i_origin || (r_norm <= NORM_W'(i_cutoff));
                end else begin
                    r_x   <= x_b;
                    r_res <= r_b;
                end
            end
            OP_LOAD: begin
                o_point_valid <= !i_cmd.idle && r_valid;
                o_vec_x       <= i_cmd.idle ? '0 : r_acc[0];
                o_vec_y       <= i_cmd.idle ? '0 : r_acc[1];
                o_vec_z       <= i_cmd.idle ? '0 : r_acc[2];
                o_vec_length  <= (i_cmd.idle || !r_valid) ? '0 : r_res[VEC_W-1:0];
                o_walk_done   <= i_cmd.idle || i_cmd.done;
            end
            default: begin
                r_sq <= r_sq;
            end
        endcase
    end

endmodule

// ===== sv/hlbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlbe_ctrl
// Sequencer: settle, accumulate, square, root, advance, settle again, deliver.
// ----------------------------------------------------------------------------
module hlbe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_restart,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  hlbe_pkg::t_walk_sts i_sts,
    output hlbe_pkg::t_walk_cmd o_walk,
    output hlbe_pkg::t_dp_cmd   o_dp
);
    import hlbe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SETTLE, S_MAC, S_SQ, S_ROOT, S_ADV, S_RESETTLE, S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_idle;
    logic             r_out_valid;
    logic             accept, load;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_walk          = '0;
        o_dp.op         = OP_NONE;
        o_dp.cnt        = r_cnt;
        o_dp.idle       = r_idle;
        o_dp.done       = i_sts.finished;
        o_walk.restart  = accept && i_restart;
        unique case (r_state)
            S_SETTLE: begin
                o_walk.step     = !i_sts.finished;
                o_walk.set_done = !i_sts.finished && i_sts.fail;
                if (!i_sts.finished && i_sts.hit) o_dp.op = OP_CLEAR;
            end
            S_MAC:      o_dp.op = OP_MAC;
            S_SQ:       o_dp.op = OP_SQ;
            S_ROOT:     o_dp.op = OP_ROOT;
            S_ADV:      o_walk.advance = 1'b1;
            S_RESETTLE: begin
                o_walk.step     = 1'b1;
                o_walk.set_done = i_sts.fail;
            end
            S_OUT:      if (load) o_dp.op = OP_LOAD;
            default:    o_dp.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_idle      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (accept) r_state <= S_SETTLE;
                S_SETTLE: begin
                    r_cnt <= '0;
                    if (i_sts.finished || i_sts.fail) begin
                        r_idle  <= 1'b1;
                        r_state <= S_OUT;
                    end else if (i_sts.hit) begin
                        r_idle  <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_cnt[3:0] == 4'b1010) begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end else if (r_cnt[1:0] == 2'd2) begin
                        r_cnt <= {1'b0, r_cnt[3:2] + 2'd1, 2'd0};
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SQ: begin
                    if (r_cnt == CNT_W'(3)) begin
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(16)) r_state <= S_ADV;
                end
                S_ADV: r_state <= S_RESETTLE;
                S_RESETTLE: if (i_sts.hit || i_sts.fail) r_state <= S_OUT;
                S_OUT: if (load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/half_lattice_ball_enumerator.sv =====
// ----------------------------------------------------------------------------
// half_lattice_ball_enumerator
// Walks half of a lattice search box, one point per beat, with length.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   tdata[0] restart
// m_axis    out  tdata x,y,z,length (32b each), tuser point_valid, tlast done
// apb       in   8 registers on a 64-bit bus at byte address 8*i
//
// A point passes from one accepted beat to the next through a settle step,
// multiply-accumulate on one 10x21 multiplier, squaring, the square-root unit
// (two bits a cycle), an advance, a further settle step, the load and the idle
// state; each extra settle step at a box edge lengthens the point.
// An idle beat goes through the settle, load and idle states. Reset is synchronous; the next beat is taken
// while a result waits, and a held output stalls the following result.
// ----------------------------------------------------------------------------
module half_lattice_ball_enumerator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // restart, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // vec_x, vec_y, vec_z, vec_length
    output logic         m_axis_tuser,   // point_valid
    output logic         m_axis_tlast,   // walk_done
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import hlbe_pkg::*;

    typedef enum logic [2:0] {
        R_BASIS1, R_BASIS2, R_BASIS3, R_CUTOFF, R_BOUND1, R_BOUND2, R_BOUND3, R_ORIGIN
    } t_reg;

    logic [BASIS_W-1:0] r_basis1, r_basis2, r_basis3;
    logic [CUT_W-1:0]   r_cutoff;
    logic [BOUND_W-1:0] r_bound1, r_bound2, r_bound3;
    logic               r_origin;
    logic               wr;
    t_reg               ridx;
    t_walk_cmd          walk_cmd;
    t_walk_sts          walk_sts;
    t_dp_cmd            dp_cmd;
    logic signed [IDX_W-1:0] i1, i2, i3;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign ridx   = t_reg'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis1 <= '0;
            r_basis2 <= '0;
            r_basis3 <= '0;
            r_cutoff <= '0;
            r_bound1 <= '0;
            r_bound2 <= '0;
            r_bound3 <= '0;
            r_origin <= 1'b0;
        end else if (wr) begin
            unique case (ridx)
                R_BASIS1: r_basis1 <= pwdata[BASIS_W-1:0];
                R_BASIS2: r_basis2 <= pwdata[BASIS_W-1:0];
                R_BASIS3: r_basis3 <= pwdata[BASIS_W-1:0];
                R_CUTOFF: r_cutoff <= pwdata[CUT_W-1:0];
                R_BOUND1: r_bound1 <= pwdata[BOUND_W-1:0];
                R_BOUND2: r_bound2 <= pwdata[BOUND_W-1:0];
                R_BOUND3: r_bound3 <= pwdata[BOUND_W-1:0];
                default:  r_origin <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            R_BASIS1: prdata = 64'(r_basis1);
            R_BASIS2: prdata = 64'(r_basis2);
            R_BASIS3: prdata = 64'(r_basis3);
            R_CUTOFF: prdata = 64'(r_cutoff);
            R_BOUND1: prdata = 64'(r_bound1);
            R_BOUND2: prdata = 64'(r_bound2);
            R_BOUND3: prdata = 64'(r_bound3);
            default:  prdata = 64'(r_origin);
        endcase
    end

    hlbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_restart   (s_axis_tdata[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (walk_sts),
        .o_walk      (walk_cmd),
        .o_dp        (dp_cmd)
    );

    hlbe_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (walk_cmd),
        .i_b1         (clamp_bound(r_bound1)),
        .i_b2         (clamp_bound(r_bound2)),
        .i_b3         (clamp_bound(r_bound3)),
        .i_inc_origin (r_origin),
        .o_sts        (walk_sts),
        .o_i1         (i1),
        .o_i2         (i2),
        .o_i3         (i3)
    );

    hlbe_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_origin      (walk_sts.origin),
        .i_i1          (i1),
        .i_i2          (i2),
        .i_i3          (i3),
        .i_basis1      (r_basis1),
        .i_basis2      (r_basis2),
        .i_basis3      (r_basis3),
        .i_cutoff      (r_cutoff),
        .o_point_valid (m_axis_tuser),
        .o_vec_x       (m_axis_tdata[31:0]),
        .o_vec_y       (m_axis_tdata[63:32]),
        .o_vec_z       (m_axis_tdata[95:64]),
        .o_vec_length  (m_axis_tdata[127:96]),
        .o_walk_done   (m_axis_tlast)
    );

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[127:96] == '0)
        else $error("length set on a point outside the ball");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken while a point is in work");

    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !walk_sts.finished || !$stable(m_axis_tvalid))
        else $error("open point delivered after the walk finished");

endmodule

// ===== tb/sv/half_lattice_ball_enumerator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_lattice_ball_enumerator_test
// Runs the half-box walk with random restarts and register settings, predicts
// every point, its norm check and length, and checks each output beat.
// ----------------------------------------------------------------------------
module half_lattice_ball_enumerator_test;
    import hlbe_pkg::*;

    localparam int REG_BASIS_ONE   = 0;
    localparam int REG_BASIS_TWO   = 1;
    localparam int REG_BASIS_THREE = 2;
    localparam int REG_CUTOFF      = 3;
    localparam int REG_BOUND_FIRST = 4;
    localparam int REG_BOUND_SECOND = 5;
    localparam int REG_BOUND_THIRD = 6;
    localparam int REG_ORIGIN      = 7;
    localparam int CYCLE_LIMIT     = 900000;
    localparam int SETTLE_CYCLES   = 80;

    typedef struct packed {
        logic        point_valid;
        logic [31:0] vec_x;
        logic [31:0] vec_y;
        logic [31:0] vec_z;
        logic [31:0] vec_length;
        logic        walk_done;
    } t_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    half_lattice_ball_enumerator DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [62:0] basis [3];
    logic [47:0] cutoff;
    int          bnd [3];
    logic        with_origin;
    t_phase      phase;
    int          n1, n2, n3;
    logic        finished;

    logic        restart_q[$];
    t_point      expected_points[$];
    int          errors = 0;
    int          points_seen = 0;
    int          inside_seen = 0;
    int          done_seen = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    int          hold_off = 0;
    bit          calm = 0;
    bit          sending = 0;

    function automatic logic [31:0] comp32(logic [62:0] p, int c);
        logic [20:0] v;
        v = p[21*c +: 21];
        return {{11{v[20]}}, v};
    endfunction

    function automatic logic [63:0] square_mag(logic [31:0] v);
        logic [31:0] a;
        logic [63:0] m;
        a = v[31] ? (~v + 32'd1) : v;
        m = 64'(a);
        return m * m;
    endfunction

    function automatic logic [31:0] int_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic bit seek_point();
        int b1, b2, b3;
        b1 = bnd[0] > INDEX_MAX ? INDEX_MAX : bnd[0];
        b2 = bnd[1] > INDEX_MAX ? INDEX_MAX : bnd[1];
        b3 = bnd[2] > INDEX_MAX ? INDEX_MAX : bnd[2];
        forever begin
            case (phase)
                PH_ORIGIN: begin
                    if (with_origin) return 1;
                    phase = PH_AXIS;
                    n3 = 1;
                end
                PH_AXIS: begin
                    if (n3 < 1) n3 = 1;
                    if (n3 <= b3) return 1;
                    phase = PH_PLANE;
                    n2 = 1;
                    n3 = -b3;
                end
                PH_PLANE: begin
                    if (n2 < 1) begin
                        n2 = 1;
                        n3 = -b3;
                    end
                    if (n2 > b2) begin
                        phase = PH_BODY;
                        n1 = 1;
                        n2 = -b2;
                        n3 = -b3;
                    end else if (n3 < -b3) n3 = -b3;
                    else if (n3 > b3) begin
                        n2++;
                        n3 = -b3;
                    end else return 1;
                end
                default: begin
                    if (n1 < 1) begin
                        n1 = 1;
                        n2 = -b2;
                        n3 = -b3;
                    end
                    if (n1 > b1) return 0;
                    if (n2 < -b2) begin
                        n2 = -b2;
                        n3 = -b3;
                    end else if (n2 > b2) begin
                        n1++;
                        n2 = -b2;
                        n3 = -b3;
                    end else if (n3 < -b3) n3 = -b3;
                    else if (n3 > b3) begin
                        n2++;
                        n3 = -b3;
                    end else return 1;
                end
            endcase
        end
    endfunction

    function automatic t_point next_point(logic restart);
        t_point      p;
        logic [31:0] v [3];
        logic [63:0] nsq;
        p = '0;
        p.walk_done = 1'b1;
        if (restart) begin
            phase = PH_ORIGIN;
            n1 = 0;
            n2 = 0;
            n3 = 0;
            finished = 0;
        end
        if (finished || !seek_point()) begin
            finished = 1;
            return p;
        end
        nsq = 0;
        for (int c = 0; c < 3; c++) begin
            v[c] = 0;
            if (phase != PH_ORIGIN)
                v[c] = 32'(n1) * comp32(basis[0], c) + 32'(n2) * comp32(basis[1], c)
                     + 32'(n3) * comp32(basis[2], c);
            nsq += square_mag(v[c]);
        end
        p.point_valid = (phase == PH_ORIGIN) || nsq <= 64'(cutoff);
        p.vec_x = v[0];
        p.vec_y = v[1];
        p.vec_z = v[2];
        p.vec_length = p.point_valid ? int_root(nsq) : 32'd0;
        if (phase == PH_ORIGIN) begin
            phase = PH_AXIS;
            n3 = 1;
        end else n3++;
        if (!seek_point()) finished = 1;
        p.walk_done = finished;
        return p;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(int idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BASIS_ONE, REG_BASIS_TWO, REG_BASIS_THREE: basis[idx] = value[62:0];
            REG_CUTOFF: cutoff = value[47:0];
            REG_BOUND_FIRST, REG_BOUND_SECOND, REG_BOUND_THIRD:
                bnd[idx - REG_BOUND_FIRST] = int'(value[7:0]);
            default: with_origin = value[0];
        endcase
    endtask

    task automatic drain();
        while (restart_q.size() != 0 || expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // small components, except in mode 1, keep the points in a useful size range
    function automatic logic [62:0] rand_basis(int mode);
        logic [62:0] b;
        b = {$urandom, $urandom};
        if (mode == 1) return b;
        for (int c = 0; c < 3; c++)
            b[21*c +: 21] = 21'($signed($urandom_range(0, 24000)) - 12000);
        return b;
    endfunction

    task automatic setting(int k);
        write_reg(REG_BASIS_ONE, (k == 0) ? 64'h7fff_ffff_ffff_ffff : 64'(rand_basis(k % 3)));
        write_reg(REG_BASIS_TWO, (k == 0) ? 64'h0 : 64'(rand_basis(k % 4)));
        write_reg(REG_BASIS_THREE, (k == 1) ? 64'h4000_0100_0000_0000 : 64'(rand_basis(0)));
        write_reg(REG_CUTOFF, (k == 0) ? 64'hffff_ffff_ffff : (k == 1) ? 64'h0 :
                  64'({$urandom, $urandom}) >> $urandom_range(16, 40));
        write_reg(REG_BOUND_FIRST, (k == 2) ? 64'd255 : 64'($urandom_range(0, 2)));
        write_reg(REG_BOUND_SECOND, (k == 3) ? 64'd255 : 64'($urandom_range(0, 3)));
        write_reg(REG_BOUND_THIRD, (k == 4) ? 64'd255 : 64'($urandom_range(0, 3)));
        write_reg(REG_ORIGIN, 64'($urandom_range(0, 1)));
    endtask

    task automatic push_items(int count, int restart_pct);
        for (int i = 0; i < count; i++)
            restart_q.push_back($urandom_range(1, 100) <= restart_pct);
        while (restart_q.size() != 0) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_points.push_back(next_point(s_axis_tdata[0]));
            void'(restart_q.pop_front());
        end
        if (s_axis_tvalid && !s_axis_tready) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
        end else begin
            if (sending && restart_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, restart_q[0]};
            end else s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_point want, got;
        if (i_rst_n) cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tlast};
            points_seen <= points_seen + 1;
            if (expected_points.size() == 0) report("unexpected beat", 64'(got), 0);
            else begin
                want = expected_points.pop_front();
                if (want.point_valid) inside_seen <= inside_seen + 1;
                if (want.walk_done) done_seen <= done_seen + 1;
                if (got.point_valid != want.point_valid)
                    report("point_valid", 64'(got.point_valid), 64'(want.point_valid));
                if (got.vec_x != want.vec_x) report("vec_x", 64'(got.vec_x), 64'(want.vec_x));
                if (got.vec_y != want.vec_y) report("vec_y", 64'(got.vec_y), 64'(want.vec_y));
                if (got.vec_z != want.vec_z) report("vec_z", 64'(got.vec_z), 64'(want.vec_z));
                if (got.vec_length != want.vec_length)
                    report("vec_length", 64'(got.vec_length), 64'(want.vec_length));
                if (got.walk_done != want.walk_done)
                    report("walk_done", 64'(got.walk_done), 64'(want.walk_done));
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            take_gap <= $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else m_axis_tready <= 1'b1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        basis = '{default: '0};
        cutoff = 0;
        bnd = '{default: 0};
        with_origin = 0;
        phase = PH_ORIGIN;
        n1 = 0;
        n2 = 0;
        n3 = 0;
        finished = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sending = 1;
        // empty walk with reset registers, then extremes and corner settings
        push_items(3, 30);
        drain();
        write_reg(REG_ORIGIN, 64'd1);
        push_items(3, 0);
        drain();
        for (int k = 0; k < 5; k++) begin
            setting(k);
            push_items(4, 25);
            drain();
        end
        hold_off = 600;
        for (int k = 5; k < 25; k++) begin
            setting(k);
            if (k == 20) calm = 1;
            push_items(25, 4);
            if (k == 12) drain();
            else begin
                sending = 0;
                drain();
                sending = 1;
            end
        end
        drain();
        $display("checked %0d points, %0d inside the ball, %0d with walk done",
                 points_seen, inside_seen, done_seen);
        $display("covered 27 register settings with restarts, stalls and a long output hold");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
